>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, quiet while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion sampled on the rising clock, also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/jsu_pkg.sv
// Shared types, constants and UTF-8 helpers of the JSON string unescaper.
// Depends on nothing; used by every module of the block.
package jsu_pkg;

  // Depth of the command queue between the decoder and the serializer.
  localparam int CMD_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_PAIR = 3'd4
  } mode_t;

  // What the tail of one request's output is, after an optional released unit.
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_RAW  = 3'd1,
    KIND_CP   = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  // One command from the decoder: optionally a held high surrogate to be
  // written as three bytes, followed by the tail that kind describes.
  typedef struct packed {
    logic        rel;
    logic [15:0] held;
    kind_t       kind;
    logic [20:0] val;
  } cmd_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h00007F) n = 3'd1;
    else if (cp <= 21'h0007FF) n = 3'd2;
    else if (cp <= 21'h00FFFF) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  // Byte j of the UTF-8 form of cp, whose length is len.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [2:0] j);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        case (j)
          3'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (j)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (j)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {2'b10, cp[17:12]};
          3'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/jsu_front.sv
// Decoder front end: tracks the string state and turns each request into a command.
// Depends on jsu_pkg.
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          end_of_input,
  output logic          cmd_valid,
  output jsu_pkg::cmd_t cmd
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] accum, accum_next;
  logic [15:0] held, held_next;
  logic [2:0]  stage, stage_next;

  logic        is_hex;
  logic [3:0]  hex_val;
  logic [15:0] acc_shift;
  logic        esc_simple;
  logic [7:0]  esc_byte;
  logic        shift_high;
  logic        shift_low;
  logic [20:0] pair_cp;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) hex_val = in_byte[3:0];
    else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) hex_val = in_byte[3:0] + 4'd9;
    else is_hex = 1'b0;
  end

  always_comb begin
    esc_simple = 1'b1;
    esc_byte   = in_byte;
    case (in_byte)
      CH_QUOTE, CH_BACKSLASH, CH_SLASH: esc_byte = in_byte;
      CH_LOWER_B: esc_byte = 8'h08;
      CH_LOWER_F: esc_byte = 8'h0C;
      CH_LOWER_N: esc_byte = 8'h0A;
      CH_LOWER_R: esc_byte = 8'h0D;
      CH_LOWER_T: esc_byte = 8'h09;
      default:    esc_simple = 1'b0;
    endcase
  end

  assign acc_shift  = {accum[11:0], hex_val};
  assign shift_high = (acc_shift >= HIGH_SURR_MIN) && (acc_shift <= HIGH_SURR_MAX);
  assign shift_low  = (acc_shift >= LOW_SURR_MIN) && (acc_shift <= LOW_SURR_MAX);
  assign pair_cp    = {1'b0, held[9:0], acc_shift[9:0]} + SUPP_BASE;

  // Next state.
  always_comb begin
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    accum_next   = accum;
    held_next    = held;
    stage_next   = stage;
    case (mode)
      MODE_IDLE: begin
        if (!end_of_input && in_byte == CH_QUOTE) mode_next = MODE_STR;
      end
      MODE_STR: begin
        if (end_of_input || in_byte == CH_QUOTE) mode_next = MODE_IDLE;
        else if (in_byte == CH_BACKSLASH) mode_next = MODE_ESC;
      end
      MODE_ESC: begin
        if (end_of_input) mode_next = MODE_IDLE;
        else if (esc_simple) mode_next = MODE_STR;
        else if (in_byte == CH_LOWER_U) begin
          mode_next    = MODE_HEX;
          hex_cnt_next = 2'd0;
          accum_next   = 16'd0;
        end else mode_next = MODE_IDLE;
      end
      MODE_HEX: begin
        if (end_of_input || !is_hex) mode_next = MODE_IDLE;
        else begin
          accum_next   = acc_shift;
          hex_cnt_next = hex_cnt + 2'd1;
          if (hex_cnt == 2'd3) begin
            if (shift_high) begin
              mode_next  = MODE_PAIR;
              held_next  = acc_shift;
              stage_next = 3'd0;
            end else mode_next = MODE_STR;
          end
        end
      end
      MODE_PAIR: begin
        if (end_of_input) mode_next = MODE_IDLE;
        else if (stage == 3'd0) begin
          if (in_byte == CH_BACKSLASH) stage_next = 3'd1;
          else if (in_byte == CH_QUOTE) mode_next = MODE_IDLE;
          else mode_next = MODE_STR;
        end else if (stage == 3'd1) begin
          if (in_byte == CH_LOWER_U) begin
            stage_next = 3'd2;
            accum_next = 16'd0;
          end else if (esc_simple) mode_next = MODE_STR;
          else mode_next = MODE_IDLE;
        end else begin
          if (!is_hex) mode_next = MODE_IDLE;
          else begin
            accum_next = acc_shift;
            stage_next = stage + 3'd1;
            if (stage == 3'd5) begin
              // A second high surrogate takes the place of the released one.
              if (!shift_low && shift_high) begin
                held_next  = acc_shift;
                stage_next = 3'd0;
              end else mode_next = MODE_STR;
            end
          end
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // Command for the serializer.
  always_comb begin
    cmd.rel  = 1'b0;
    cmd.held = held;
    cmd.kind = KIND_NONE;
    cmd.val  = {13'd0, in_byte};
    case (mode)
      MODE_IDLE: begin
        if (end_of_input || in_byte != CH_QUOTE) cmd.kind = KIND_ERR;
      end
      MODE_STR: begin
        if (end_of_input) cmd.kind = KIND_ERR;
        else if (in_byte == CH_QUOTE) cmd.kind = KIND_DONE;
        else if (in_byte != CH_BACKSLASH) cmd.kind = KIND_RAW;
      end
      MODE_ESC: begin
        if (end_of_input) cmd.kind = KIND_ERR;
        else if (esc_simple) begin
          cmd.kind = KIND_RAW;
          cmd.val  = {13'd0, esc_byte};
        end else if (in_byte != CH_LOWER_U) cmd.kind = KIND_ERR;
      end
      MODE_HEX: begin
        if (end_of_input || !is_hex) cmd.kind = KIND_ERR;
        else if (hex_cnt == 2'd3 && !shift_high) begin
          cmd.kind = KIND_CP;
          cmd.val  = {5'd0, acc_shift};
        end
      end
      MODE_PAIR: begin
        if (end_of_input) begin
          cmd.rel  = 1'b1;
          cmd.kind = KIND_ERR;
        end else if (stage == 3'd0) begin
          if (in_byte != CH_BACKSLASH) begin
            cmd.rel  = 1'b1;
            cmd.kind = (in_byte == CH_QUOTE) ? KIND_DONE : KIND_RAW;
          end
        end else if (stage == 3'd1) begin
          if (in_byte != CH_LOWER_U) begin
            cmd.rel = 1'b1;
            if (esc_simple) begin
              cmd.kind = KIND_RAW;
              cmd.val  = {13'd0, esc_byte};
            end else cmd.kind = KIND_ERR;
          end
        end else if (!is_hex) begin
          cmd.rel  = 1'b1;
          cmd.kind = KIND_ERR;
        end else if (stage == 3'd5) begin
          if (shift_low) begin
            cmd.kind = KIND_CP;
            cmd.val  = pair_cp;
          end else begin
            cmd.rel = 1'b1;
            if (!shift_high) begin
              cmd.kind = KIND_CP;
              cmd.val  = {5'd0, acc_shift};
            end
          end
        end
      end
      default: cmd.kind = KIND_ERR;
    endcase
  end

  assign cmd_valid = accept && (cmd.rel || cmd.kind != KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hex_cnt <= 2'd0;
      accum   <= 16'd0;
      held    <= 16'd0;
      stage   <= 3'd0;
    end else if (accept) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      accum   <= accum_next;
      held    <= held_next;
      stage   <= stage_next;
    end
  end

endmodule

>>> hw/rtl/jsu_fifo.sv
// Command queue between the decoder and the byte serializer.
// Depends on jsu_pkg for the command type.
module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output jsu_pkg::cmd_t rd_data,
  output logic          full,
  output logic          nonempty
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/jsu_back.sv
// Back end: expands one command at a time into results, one per cycle while pop is high.
// Depends on jsu_pkg for the command type and the UTF-8 helpers.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_nonempty,
  input  jsu_pkg::cmd_t q_data,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          string_done,
  output logic          error_flag,
  output logic          last
);
  import jsu_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] idx;

  logic [2:0] base;
  logic [2:0] tail_len;
  logic [2:0] cp_len;
  logic [2:0] total;
  logic [2:0] j;
  logic       is_last;

  assign cp_len = utf8_len(cur.val);
  assign base   = cur.rel ? 3'd3 : 3'd0;

  always_comb begin
    case (cur.kind)
      KIND_RAW, KIND_DONE, KIND_ERR: tail_len = 3'd1;
      KIND_CP:  tail_len = cp_len;
      default:  tail_len = 3'd0;
    endcase
  end

  assign total   = base + tail_len;
  assign j       = idx - base;
  assign is_last = (idx == total - 3'd1);

  always_comb begin
    out_byte    = 8'h00;
    byte_valid  = 1'b0;
    string_done = 1'b0;
    error_flag  = 1'b0;
    if (cur.rel && idx < 3'd3) begin
      out_byte   = utf8_byte({5'd0, cur.held}, 3'd3, idx);
      byte_valid = 1'b1;
    end else begin
      case (cur.kind)
        KIND_RAW: begin
          out_byte   = cur.val[7:0];
          byte_valid = 1'b1;
        end
        KIND_CP: begin
          out_byte   = utf8_byte(cur.val, cp_len, j);
          byte_valid = 1'b1;
        end
        KIND_DONE: string_done = 1'b1;
        KIND_ERR:  error_flag = 1'b1;
        default:   out_byte = 8'h00;
      endcase
    end
  end

  assign empty = !cur_valid;
  assign last  = is_last;
  assign q_pop = q_nonempty && (!cur_valid || (pop && is_last));

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (!cur_valid || (pop && is_last)) begin
      cur_valid <= q_nonempty;
      idx       <= 3'd0;
    end else if (pop) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

>>> hw/rtl/json_string_unescape.sv
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// The block takes the raw bytes of one quoted JSON string, opening quote first,
// one request per clock, and gives out the decoded UTF-8 bytes as result
// requests: plain bytes pass through, the simple escapes become their
// characters, and \uXXXX escapes, surrogate pairs included, are written as
// UTF-8. A result with string_done marks the closing quote and one with
// error_flag marks malformed or unterminated input; bytes already given out
// for that string should then be discarded. The last flag marks the final
// result caused by one input request. An input request is decoded in the cycle
// it is accepted and yields zero to six results. Its command is written into
// the queue when the request is accepted, and the serializer loads it from the
// queue once it is free; results are driven from the serializer's registered
// command. Results then leave at one per cycle while pop stays
// high. Input is taken every cycle as long as the command
// queue (FIFO_DEPTH entries, one per input request that yields any result)
// has room, so the sustained input rate is one request per cycle when most
// bytes decode to a single result, and the rate of long escapes is set by the
// serializer writing one output byte per cycle.
module json_string_unescape #(
  parameter int FIFO_DEPTH = jsu_pkg::CMD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic       error_flag,
  output logic       last
);
  import jsu_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t q_data;
  logic q_pop;
  logic q_nonempty;

  // An input request is taken whenever the command queue has room, even one
  // that yields no result, so the decoder state always moves in step.
  assign accept = push && !full;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .full     (full),
    .nonempty (q_nonempty)
  );

  // The serializer holds the command in work and walks its bytes in order.
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_done (string_done),
    .error_flag  (error_flag),
    .last        (last)
  );

endmodule

>>> hw/rtl/jsu_checker.sv
// Port-level checker of the JSON string unescaper, with its bind statement.
// Depends on assert_macros.svh and the top level json_string_unescape.
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       end_of_input,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       string_done,
  input logic       error_flag,
  input logic       last
);

  logic in_seen;
  assign in_seen = push && !full && (in_byte == in_byte) && (end_of_input == end_of_input);

  // A waiting result that is not taken stays put.
  `ASSERT_CLK(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_valid) && $stable(string_done) && $stable(error_flag) && $stable(last)), "result changed while stalled")

  // A done or error mark carries no byte and closes the results of its request.
  `ASSERT_CLK(a_mark, clk, rst, (!empty && (string_done || error_flag)) |-> (!byte_valid && out_byte == 8'h00 && last && !(string_done && error_flag)), "malformed done or error result")

  // Every result is exactly one of byte, done and error.
  `ASSERT_CLK(a_kind, clk, rst, (!empty || in_seen) |-> (empty || $onehot({byte_valid, string_done, error_flag})), "result kind not unique")

  // Reset leaves no result waiting.
  `ASSERT_CLK_NR(a_reset, clk, rst |=> empty, "result waiting after reset")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_unescape: random quoted strings, escapes and surrogates.
// Depends on jsu_pkg for the character and surrogate constants and on the block's top level.
module tb_top;
  import jsu_pkg::*;

  // One decoded result request, in the order of the result ports.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       err;
    logic       last;
  } decoded_t;

  // One raw input request.
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } raw_t;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 400;

  // This class tracks the unescaper's decode state on its own and keeps the
  // decoded bytes still awaited from the block, oldest first.
  class unescape_check;
    mode_t       mode;
    logic [2:0]  nibbles_seen;
    logic [15:0] unit;
    logic [15:0] held_unit;
    logic        holding;
    logic [2:0]  look_pos;
    decoded_t    awaited[$];
    int          mismatches;

    function new();
      mismatches = 0;
      go_idle();
    endfunction

    function void go_idle();
      mode         = MODE_IDLE;
      nibbles_seen = 3'd0;
      unit         = 16'h0000;
      held_unit    = 16'h0000;
      holding      = 1'b0;
      look_pos     = 3'd0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] data, logic valid, logic done, logic err);
      awaited.push_back({data, valid, done, err, 1'b0});
    endfunction

    function void emit_err();
      emit(8'h00, 1'b0, 1'b0, 1'b1);
      go_idle();
    endfunction

    function void emit_utf8(logic [20:0] cp);
      if (cp <= 21'h00007F) begin
        emit({1'b0, cp[6:0]}, 1'b1, 1'b0, 1'b0);
      end else if (cp <= 21'h0007FF) begin
        emit({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
      end else if (cp <= 21'h00FFFF) begin
        emit({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
      end else begin
        emit({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
      end
    endfunction

    // The held high surrogate goes out alone as three bytes.
    function void release_held();
      emit_utf8({5'd0, held_unit});
      holding   = 1'b0;
      held_unit = 16'h0000;
      look_pos  = 3'd0;
    endfunction

    function void finish_unit(logic [15:0] u);
      unit         = 16'h0000;
      nibbles_seen = 3'd0;
      if (u >= HIGH_SURR_MIN && u <= HIGH_SURR_MAX) begin
        held_unit = u;
        holding   = 1'b1;
        look_pos  = 3'd0;
        mode      = MODE_PAIR;
      end else begin
        emit_utf8({5'd0, u});
        mode = MODE_STR;
      end
    endfunction

    function void string_byte(logic [7:0] c);
      if (c == CH_QUOTE) begin
        emit(8'h00, 1'b0, 1'b1, 1'b0);
        go_idle();
      end else if (c == CH_BACKSLASH) begin
        mode = MODE_ESC;
      end else begin
        emit(c, 1'b1, 1'b0, 1'b0);
        mode = MODE_STR;
      end
    endfunction

    function void escape_byte(logic [7:0] c);
      logic [7:0] b;
      case (c)
        CH_QUOTE, CH_BACKSLASH, CH_SLASH: b = c;
        CH_LOWER_B: b = 8'h08;
        CH_LOWER_F: b = 8'h0C;
        CH_LOWER_N: b = 8'h0A;
        CH_LOWER_R: b = 8'h0D;
        CH_LOWER_T: b = 8'h09;
        CH_LOWER_U: begin
          mode         = MODE_HEX;
          nibbles_seen = 3'd0;
          unit         = 16'h0000;
          return;
        end
        default: begin
          emit_err();
          return;
        end
      endcase
      emit(b, 1'b1, 1'b0, 1'b0);
      mode = MODE_STR;
    endfunction

    // Works out every result that one accepted raw byte causes.
    function void note_raw_byte(logic [7:0] c, logic eoi);
      int first;
      int hv;
      logic [15:0] lo;
      first = awaited.size();
      case (mode)
        MODE_IDLE: begin
          if (eoi || c != CH_QUOTE) emit_err();
          else mode = MODE_STR;
        end
        MODE_STR: begin
          if (eoi) emit_err();
          else string_byte(c);
        end
        MODE_ESC: begin
          if (eoi) emit_err();
          else escape_byte(c);
        end
        MODE_HEX: begin
          hv = eoi ? -1 : hex_of(c);
          if (hv < 0) begin
            emit_err();
          end else begin
            unit         = {unit[11:0], hv[3:0]};
            nibbles_seen = nibbles_seen + 3'd1;
            if (nibbles_seen >= 3'd4) finish_unit(unit);
          end
        end
        MODE_PAIR: begin
          if (eoi) begin
            release_held();
            emit_err();
          end else if (look_pos == 3'd0) begin
            if (c == CH_BACKSLASH) begin
              look_pos = 3'd1;
            end else begin
              release_held();
              string_byte(c);
            end
          end else if (look_pos == 3'd1) begin
            if (c == CH_LOWER_U) begin
              look_pos = 3'd2;
              unit     = 16'h0000;
            end else begin
              release_held();
              escape_byte(c);
            end
          end else begin
            hv = hex_of(c);
            if (hv < 0) begin
              release_held();
              emit_err();
            end else begin
              unit     = {unit[11:0], hv[3:0]};
              look_pos = look_pos + 3'd1;
              if (look_pos >= 3'd6) begin
                lo = unit;
                if (lo >= LOW_SURR_MIN && lo <= LOW_SURR_MAX) begin
                  // Both units carry ten payload bits below their range base.
                  emit_utf8({1'b0, held_unit[9:0], lo[9:0]} + SUPP_BASE);
                  holding   = 1'b0;
                  held_unit = 16'h0000;
                  look_pos  = 3'd0;
                  unit      = 16'h0000;
                  mode      = MODE_STR;
                end else begin
                  release_held();
                  finish_unit(lo);
                end
              end
            end
          end
        end
        default: emit_err();
      endcase
      if (awaited.size() > first) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_decoded(decoded_t got);
      decoded_t want;
      if (awaited.size() == 0) begin
        $error("result out_byte %h arrived with nothing awaited", got.data);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("byte_valid", 8'(want.valid), 8'(got.valid));
      compare_field("string_done", 8'(want.done), 8'(got.done));
      compare_field("error_flag", 8'(want.err), 8'(got.err));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       error_flag;
  logic       last;

  // Chances, in percent, that the sender and the receiver sit out a cycle.
  int send_gap_pct = 23;
  int pop_gap_pct  = 68;
  // Raised once by the sender side to make the receiver hold off for a while.
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  unescape_check decoded_check = new();
  raw_t          byte_stream[$];

  json_string_unescape dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .end_of_input(end_of_input),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_done (string_done),
    .error_flag  (error_flag),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Building the raw byte stream. Everything is generated up front; the
  // sender then walks the queue request by request.
  // ---------------------------------------------------------------------
  function automatic void add(logic [7:0] b);
    byte_stream.push_back({b, 1'b0});
  endfunction

  // End of input carries a random byte, which the block must ignore.
  function automatic void add_eoi();
    byte_stream.push_back({8'($urandom_range(0, 255)), 1'b1});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  // Hex digits a-f come out in either case at random.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic void add_unit(logic [15:0] u);
    add(CH_BACKSLASH);
    add(CH_LOWER_U);
    for (int k = 3; k >= 0; k--) add(hex_char(u[4 * k +: 4]));
  endfunction

  function automatic logic [15:0] rand_high();
    return HIGH_SURR_MIN + 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] rand_low();
    return LOW_SURR_MIN + 16'($urandom_range(0, 1023));
  endfunction

  // Any unit that cannot finish a pair; half of them are drawn from the high surrogates.
  function automatic logic [15:0] rand_non_low();
    logic [15:0] u;
    if ($urandom_range(0, 1)) return rand_high();
    do u = 16'($urandom_range(0, 16'hFFFF)); while (u >= LOW_SURR_MIN && u <= LOW_SURR_MAX);
    return u;
  endfunction

  // A byte that stands for itself inside a string.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BACKSLASH;
      2: return CH_SLASH;
      3: return CH_LOWER_B;
      4: return CH_LOWER_F;
      5: return CH_LOWER_N;
      6: return CH_LOWER_R;
      default: return CH_LOWER_T;
    endcase
  endfunction

  function automatic logic [7:0] bad_escape();
    logic [7:0] c;
    bit ok;
    do begin
      c = 8'($urandom_range(0, 255));
      case (c)
        CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOWER_B, CH_LOWER_F,
        CH_LOWER_N, CH_LOWER_R, CH_LOWER_T, CH_LOWER_U: ok = 1'b0;
        default: ok = 1'b1;
      endcase
    end while (!ok);
    return c;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (decoded_check.hex_of(c) >= 0);
    return c;
  endfunction

  // One piece of well-formed string content.
  function automatic void add_piece();
    case ($urandom_range(0, 10))
      0, 1, 2: add(plain_char());
      3: begin
        add(CH_BACKSLASH);
        add(simple_escape());
      end
      4: add_unit(16'($urandom_range(0, 16'hFFFF)));
      // Short units reach the one- and two-byte forms of UTF-8.
      5: add_unit(16'($urandom_range(0, 16'h07FF)));
      6: begin
        add_unit(rand_high());
        add_unit(rand_low());
      end
      // A held high surrogate whose lookahead breaks off at some point.
      7: begin
        add_unit(rand_high());
        case ($urandom_range(0, 2))
          0: add(plain_char());
          1: begin
            add(CH_BACKSLASH);
            add(simple_escape());
          end
          default: add_unit(rand_non_low());
        endcase
      end
      8: add_unit(rand_low());
      9: add(8'h80 + 8'($urandom_range(0, 127)));
      default: add_unit(16'hFFFF - 16'($urandom_range(0, 15)));
    endcase
  endfunction

  // Mostly complete strings with random content; now and then idle noise or
  // a string that ends in one of the error cases.
  function automatic void add_random_string();
    logic [7:0] c;
    int k;
    if ($urandom_range(0, 99) < 10) begin
      if ($urandom_range(0, 3) == 0) begin
        add_eoi();
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        add(c);
      end
      return;
    end
    add(CH_QUOTE);
    repeat ($urandom_range(0, 6)) add_piece();
    case ($urandom_range(0, 19))
      0: add_eoi();
      1: begin
        add(CH_BACKSLASH);
        add(bad_escape());
      end
      2: begin
        add(CH_BACKSLASH);
        add(CH_LOWER_U);
        k = $urandom_range(0, 3);
        repeat (k) add(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1)) add(bad_hex());
        else add_eoi();
      end
      // Bad hex or end of input inside the lookahead for a low surrogate.
      3: begin
        add_unit(rand_high());
        add(CH_BACKSLASH);
        add(CH_LOWER_U);
        k = $urandom_range(0, 3);
        repeat (k) add(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 1)) add(bad_hex());
        else add_eoi();
      end
      4: begin
        add_unit(rand_high());
        if ($urandom_range(0, 1)) add(CH_BACKSLASH);
        add_eoi();
      end
      default: add(CH_QUOTE);
    endcase
  endfunction

  // Offers one raw byte until the block takes it. Each pass through the
  // loop starts at a falling edge, so push is assigned once per step.
  task automatic offer_raw(raw_t r);
    bit taken = 1'b0;
    while (!taken) begin
      if ($urandom_range(0, 99) < send_gap_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end else begin
        push         <= 1'b1;
        in_byte      <= r.b;
        end_of_input <= r.eoi;
        @(posedge clk);
        taken = !full;
      end
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge. A result can
  // only show up once its command is through the queue and serializer, so
  // noting the input before checking the output in the same edge is safe.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) decoded_check.note_raw_byte(in_byte, end_of_input);
      if (pop && !empty) begin
        decoded_check.check_decoded('{data: out_byte, valid: byte_valid, done: string_done,
                                       err: error_flag, last: last});
      end
    end
  end

  // Receiver: pops at random, and once holds off for a long stretch that it
  // counts itself, so that the command queue fills and full is seen.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_gap_pct);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL json_string_unescape");
    $finish;
  end

  initial begin : sender
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: missing opening quote and end of input while idle,
    // the byte extremes passed through, an escaped slash, a held high
    // surrogate released by a plain byte, a full surrogate pair, a bad
    // escape, bad hex and end of input inside a string.
    add(8'h78);
    add_eoi();
    add(CH_QUOTE);
    add(8'h00);
    add(8'hFF);
    add_text("\\/\\uDBFFz\"");
    add_text("\"\\uD800\\udfff\"");
    add_text("\"\\q");
    add_text("\"\\uG");
    add(CH_QUOTE);
    add_eoi();
    n = byte_stream.size() + RANDOM_ITEMS;
    while (byte_stream.size() < n) add_random_string();

    n = byte_stream.size();
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        send_gap_pct = 68;
        pop_gap_pct  = 23;
      end
      if (i == 2 * n / 3) begin
        // From here on nobody idles; the receiver's hold-off lets the sender
        // run into a full block.
        send_gap_pct = 0;
        pop_gap_pct  = 0;
        hold_request = 1'b1;
      end
      if (i == 5 * n / 6) begin
        // Let the block run dry before the rest of the stream.
        push <= 1'b0;
        do @(negedge clk); while (decoded_check.outstanding() != 0);
      end
      offer_raw(byte_stream[i]);
    end
    push <= 1'b0;

    // Wait for the last results, then a little longer so that any stray
    // result the block might still give out is caught.
    do @(negedge clk); while (decoded_check.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (decoded_check.mismatches == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

endmodule
